// ===== hdl/skvt_pkg.sv =====
package skvt_pkg;

  // Input word: one table operation.
  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] key;
    logic [1:0]         value_type;
    logic [31:0]        value;
  } in_word_t;

  // Output word: one result.
  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] entry_key;
    logic [1:0]         entry_type;
    logic [31:0]        entry_value;
    logic               last;
  } out_word_t;

  // One stored table entry.
  typedef struct packed {
    logic signed [31:0] key;
    logic [1:0]         etype;
    logic [31:0]        evalue;
  } entry_t;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_LOOKUP = 2'd1;
  localparam logic [1:0] KIND_LIST   = 2'd2;

  localparam logic [1:0] TYPE_CHAR = 2'd2;
  localparam logic [1:0] TYPE_BAD  = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_DUP      = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_MISMATCH = 3'd4;
  localparam logic [2:0] ST_EMPTY    = 3'd5;

  typedef enum logic [2:0] {
    IDX_HOLD  = 3'd0,
    IDX_CLR   = 3'd1,
    IDX_INC   = 3'd2,
    IDX_DEC   = 3'd3,
    IDX_COUNT = 3'd4
  } idx_op_e;

  // Source of a result field.
  typedef enum logic [1:0] {
    SEL_ZERO = 2'd0,
    SEL_RD   = 2'd1,
    SEL_ITEM = 2'd2
  } sel_e;

  typedef struct packed {
    logic       item_load;
    idx_op_e    idx_op;
    logic       pos_load;
    logic       rd_en;
    logic       rd_prev;
    logic       wr_shift;
    logic       wr_new;
    logic       cnt_inc;
    logic       res_load;
    logic [2:0] res_status;
    sel_e       res_type_sel;
    sel_e       res_value_sel;
    logic       res_key_zero;
    logic       out_from_res;
    logic       out_from_rd;
  } cmd_t;

  typedef struct packed {
    logic [1:0] in_kind;
    logic [1:0] kind;
    logic       tag_bad;
    logic       count_zero;
    logic       full;
    logic       at_end;
    logic       key_lt;
    logic       key_eq;
    logic       type_eq;
    logic       at_pos;
    logic       list_last;
    logic       out_free;
  } sts_t;

endpackage

// ===== hdl/skvt_datapath.sv =====
module skvt_datapath #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  skvt_pkg::in_word_t   in_word_i,
  input  skvt_pkg::cmd_t       cmd_i,
  output skvt_pkg::sts_t       sts_o,
  output logic                 out_valid_o,
  output skvt_pkg::out_word_t  out_word_o,
  input  logic                 out_stall_i
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  skvt_pkg::entry_t    entry_mem [TABLE_DEPTH];
  skvt_pkg::entry_t    rd_q;
  skvt_pkg::in_word_t  item_q;
  logic [CW-1:0]       idx_q, idx_d;
  logic [CW-1:0]       pos_q;
  logic [CW-1:0]       count_q;
  skvt_pkg::out_word_t res_q, res_d;
  skvt_pkg::out_word_t out_q, out_d;
  logic                out_valid_q, out_valid_d;

  logic [CW-1:0]       idx_m1;
  logic [AW-1:0]       rd_addr;
  logic                wr_en;
  skvt_pkg::entry_t    wr_data;
  skvt_pkg::entry_t    new_entry;
  logic [31:0]         item_value;

  assign idx_m1  = idx_q - CW'(1);
  assign rd_addr = cmd_i.rd_prev ? idx_m1[AW-1:0] : idx_q[AW-1:0];

  // Characters keep only their low byte.
  assign item_value = (item_q.value_type == skvt_pkg::TYPE_CHAR) ?
                      {24'd0, item_q.value[7:0]} : item_q.value;

  assign new_entry.key    = item_q.key;
  assign new_entry.etype  = item_q.value_type;
  assign new_entry.evalue = item_value;

  assign wr_en   = cmd_i.wr_shift | cmd_i.wr_new;
  assign wr_data = cmd_i.wr_new ? new_entry : rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_mem[idx_q[AW-1:0]] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_q <= entry_mem[rd_addr];
    end
  end

  always_comb begin
    case (cmd_i.idx_op)
      skvt_pkg::IDX_CLR:   idx_d = '0;
      skvt_pkg::IDX_INC:   idx_d = idx_q + CW'(1);
      skvt_pkg::IDX_DEC:   idx_d = idx_m1;
      skvt_pkg::IDX_COUNT: idx_d = count_q;
      default:             idx_d = idx_q;
    endcase
  end

  always_comb begin
    res_d.status    = cmd_i.res_status;
    res_d.entry_key = cmd_i.res_key_zero ? 32'sd0 : item_q.key;
    case (cmd_i.res_type_sel)
      skvt_pkg::SEL_RD:   res_d.entry_type = rd_q.etype;
      skvt_pkg::SEL_ITEM: res_d.entry_type = item_q.value_type;
      default:            res_d.entry_type = 2'd0;
    endcase
    case (cmd_i.res_value_sel)
      skvt_pkg::SEL_RD:   res_d.entry_value = rd_q.evalue;
      skvt_pkg::SEL_ITEM: res_d.entry_value = item_value;
      default:            res_d.entry_value = 32'd0;
    endcase
    res_d.last = 1'b1;
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q & out_stall_i;
    if (cmd_i.out_from_res) begin
      out_d       = res_q;
      out_valid_d = 1'b1;
    end else if (cmd_i.out_from_rd) begin
      out_d.status      = skvt_pkg::ST_OK;
      out_d.entry_key   = rd_q.key;
      out_d.entry_type  = rd_q.etype;
      out_d.entry_value = rd_q.evalue;
      out_d.last        = sts_o.list_last;
      out_valid_d       = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.item_load) begin
      item_q <= in_word_i;
    end
    if (cmd_i.pos_load) begin
      pos_q <= idx_q;
    end
    if (cmd_i.res_load) begin
      res_q <= res_d;
    end
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      if (cmd_i.cnt_inc) begin
        count_q <= count_q + CW'(1);
      end
    end
  end

  assign sts_o.in_kind    = in_word_i.kind;
  assign sts_o.kind       = item_q.kind;
  assign sts_o.tag_bad    = (item_q.value_type == skvt_pkg::TYPE_BAD);
  assign sts_o.count_zero = (count_q == '0);
  assign sts_o.full       = (count_q == CW'(TABLE_DEPTH));
  assign sts_o.at_end     = (idx_q == count_q);
  assign sts_o.key_lt     = (rd_q.key < item_q.key);
  assign sts_o.key_eq     = (rd_q.key == item_q.key);
  assign sts_o.type_eq    = (rd_q.etype == item_q.value_type);
  assign sts_o.at_pos     = (idx_q == pos_q);
  assign sts_o.list_last  = (idx_q == count_q - CW'(1));
  assign sts_o.out_free   = ~out_valid_q | ~out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// ===== hdl/skvt_ctrl.sv =====
module skvt_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  skvt_pkg::sts_t  sts_i,
  output skvt_pkg::cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SREAD = 3'd1;  // search: issue read or finish
  localparam logic [2:0] S_SCHK  = 3'd2;  // search: compare read entry
  localparam logic [2:0] S_SHRD  = 3'd3;  // shift: read entry below
  localparam logic [2:0] S_SHWR  = 3'd4;  // shift: write it one up
  localparam logic [2:0] S_EMIT  = 3'd5;
  localparam logic [2:0] S_LREAD = 3'd6;
  localparam logic [2:0] S_LOUT  = 3'd7;

  logic [2:0] state_q, state_d;
  logic       is_lookup;

  assign is_lookup  = (sts_i.kind == skvt_pkg::KIND_LOOKUP);
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.item_load = 1'b1;
          cmd_o.idx_op    = skvt_pkg::IDX_CLR;
          case (sts_i.in_kind)
            skvt_pkg::KIND_INSERT, skvt_pkg::KIND_LOOKUP: begin
              state_d = S_SREAD;
            end
            skvt_pkg::KIND_LIST: begin
              if (sts_i.count_zero) begin
                cmd_o.res_load     = 1'b1;
                cmd_o.res_status   = skvt_pkg::ST_EMPTY;
                cmd_o.res_key_zero = 1'b1;
                state_d            = S_EMIT;
              end else begin
                state_d = S_LREAD;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_SREAD: begin
        if (!is_lookup && sts_i.tag_bad) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = skvt_pkg::ST_MISMATCH;
          state_d          = S_EMIT;
        end else if (sts_i.at_end) begin
          if (is_lookup) begin
            cmd_o.res_load   = 1'b1;
            cmd_o.res_status = skvt_pkg::ST_NOTFOUND;
            state_d          = S_EMIT;
          end else if (sts_i.full) begin
            cmd_o.res_load   = 1'b1;
            cmd_o.res_status = skvt_pkg::ST_FULL;
            state_d          = S_EMIT;
          end else begin
            cmd_o.pos_load = 1'b1;
            state_d        = S_SHRD;
          end
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_SCHK;
        end
      end
      S_SCHK: begin
        if (sts_i.key_lt) begin
          cmd_o.idx_op = skvt_pkg::IDX_INC;
          state_d      = S_SREAD;
        end else if (sts_i.key_eq) begin
          cmd_o.res_load     = 1'b1;
          cmd_o.res_type_sel = skvt_pkg::SEL_RD;
          state_d            = S_EMIT;
          if (!is_lookup) begin
            cmd_o.res_status = skvt_pkg::ST_DUP;
          end else if (sts_i.type_eq) begin
            cmd_o.res_status    = skvt_pkg::ST_OK;
            cmd_o.res_value_sel = skvt_pkg::SEL_RD;
          end else begin
            cmd_o.res_status = skvt_pkg::ST_MISMATCH;
          end
        end else if (is_lookup) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = skvt_pkg::ST_NOTFOUND;
          state_d          = S_EMIT;
        end else if (sts_i.full) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = skvt_pkg::ST_FULL;
          state_d          = S_EMIT;
        end else begin
          cmd_o.pos_load = 1'b1;
          cmd_o.idx_op   = skvt_pkg::IDX_COUNT;
          state_d        = S_SHRD;
        end
      end
      S_SHRD: begin
        if (sts_i.at_pos) begin
          cmd_o.wr_new        = 1'b1;
          cmd_o.cnt_inc       = 1'b1;
          cmd_o.res_load      = 1'b1;
          cmd_o.res_status    = skvt_pkg::ST_OK;
          cmd_o.res_type_sel  = skvt_pkg::SEL_ITEM;
          cmd_o.res_value_sel = skvt_pkg::SEL_ITEM;
          state_d             = S_EMIT;
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_prev = 1'b1;
          state_d       = S_SHWR;
        end
      end
      S_SHWR: begin
        cmd_o.wr_shift = 1'b1;
        cmd_o.idx_op   = skvt_pkg::IDX_DEC;
        state_d        = S_SHRD;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_from_res = 1'b1;
          state_d            = S_IDLE;
        end
      end
      S_LREAD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_LOUT;
      end
      S_LOUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_from_rd = 1'b1;
          if (sts_i.list_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.idx_op = skvt_pkg::IDX_INC;
            state_d      = S_LREAD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/sorted_key_value_table.sv =====
// Sorted key/value table: up to TABLE_DEPTH typed entries kept in ascending
// signed-key order in a single-port-write, registered-read memory.
// Input channel (in_valid_i / in_stall_o / in_word_i): one word per
// operation - insert, lookup or list. Output channel (out_valid_o /
// out_stall_i / out_word_o): result words; insert and lookup give one word,
// list gives one word per entry (or one "empty" word), last marks the end.
// Words move on a rising edge with valid high and stall low.
// One operation is worked at a time; in_stall_o is high from the cycle
// after acceptance until the controller is back in idle.
// With N entries stored, each entry the search passes or an insert shifts up
// takes a memory read, then a compare or a write-back.
// Results go through an output register, so a stalled receiver holds the
// current word steady and only the controller waits; a new word is taken
// once the pending result has moved into that register.
// Reset clears the entry count, the controller and the output valid; the
// memory itself is not cleared, since entries past the count are never read.
// Unused kind three is taken and dropped without a result.
module sorted_key_value_table #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  skvt_pkg::in_word_t   in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output skvt_pkg::out_word_t  out_word_o
);

  skvt_pkg::cmd_t cmd;
  skvt_pkg::sts_t sts;

  // Sequencer: search, shift, list and emit steps.
  skvt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Entry memory, index/count registers, result and output registers.
  skvt_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o),
    .out_stall_i (out_stall_i)
  );

endmodule

// ===== test/testbench.sv =====
module testbench;

  localparam int DEPTH            = 16;
  localparam int RANDOM_PER_PHASE = 108;      // four phases; with the script about 460 words
  localparam int DRAIN_CYCLES     = 100;      // covers a full-table search after the last word
  localparam int CYCLE_LIMIT      = 1_500_000;

  // Tags and kinds the package leaves unnamed.
  localparam logic [1:0] TYPE_INT    = 2'd0;
  localparam logic [1:0] TYPE_FLOAT  = 2'd1;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;

  // One row of the directed script. Rows with known_result set carry the
  // word the block must return; the others are checked by the shadow table.
  typedef struct {
    skvt_pkg::in_word_t  op;
    bit                  known_result;
    skvt_pkg::out_word_t result;
  } script_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  skvt_pkg::in_word_t  in_word = '0;
  logic                in_stall;
  logic                out_valid;
  logic                out_stall = 1'b0;
  skvt_pkg::out_word_t out_word;

  // Travel alongside in_word so that the acceptance edge sees the matching pair.
  bit                  word_known = 1'b0;
  skvt_pkg::out_word_t word_result = '0;

  // Shadow copy of the table, advanced once per accepted word.
  skvt_pkg::entry_t    shadow [DEPTH];
  int                  shadow_count = 0;
  skvt_pkg::out_word_t awaited_words [$];

  script_row_t script [$];

  int gap_pct = 0;      // sender idle chance per cycle
  int hold_pct = 0;     // receiver stall chance per cycle
  int gap_by_phase [4]  = '{0, 79, 0, 15};
  int hold_by_phase [4] = '{0, 0, 79, 15};

  int fail_count = 0;
  int checked_words = 0;
  int applied_ops = 0;
  int ignored_ops = 0;
  int list_ops = 0;
  int cycle_count = 0;

  sorted_key_value_table #(.TABLE_DEPTH(DEPTH)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic skvt_pkg::in_word_t op_word(logic [1:0] kind,
                                                 logic signed [31:0] key,
                                                 logic [1:0] tag, logic [31:0] value);
    skvt_pkg::in_word_t w;
    w.kind       = kind;
    w.key        = key;
    w.value_type = tag;
    w.value      = value;
    return w;
  endfunction

  // Single-word result; insert, lookup and empty list always end here.
  function automatic skvt_pkg::out_word_t done_word(logic [2:0] status,
                                                    logic signed [31:0] key,
                                                    logic [1:0] tag, logic [31:0] value);
    skvt_pkg::out_word_t r;
    r.status      = status;
    r.entry_key   = key;
    r.entry_type  = tag;
    r.entry_value = value;
    r.last        = 1'b1;
    return r;
  endfunction

  function automatic void add_row(skvt_pkg::in_word_t op, bit known,
                                  skvt_pkg::out_word_t result);
    script_row_t row;
    row.op           = op;
    row.known_result = known;
    row.result       = result;
    script.push_back(row);
  endfunction

  function automatic void log_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endfunction

  // Apply one operation to the shadow table and queue the words it yields.
  function automatic void apply_table_op(skvt_pkg::in_word_t w);
    int pos;
    logic [31:0] stored;
    skvt_pkg::out_word_t r;
    pos = 0;
    if (w.kind == skvt_pkg::KIND_INSERT) begin
      if (w.value_type == skvt_pkg::TYPE_BAD) begin
        awaited_words.push_back(done_word(skvt_pkg::ST_MISMATCH, w.key, '0, '0));
        return;
      end
      while (pos < shadow_count && $signed(shadow[pos].key) < $signed(w.key)) pos++;
      if (pos < shadow_count && shadow[pos].key == w.key) begin
        // duplicate wins over full
        awaited_words.push_back(done_word(skvt_pkg::ST_DUP, w.key, shadow[pos].etype, '0));
        return;
      end
      if (shadow_count >= DEPTH) begin
        awaited_words.push_back(done_word(skvt_pkg::ST_FULL, w.key, '0, '0));
        return;
      end
      stored = (w.value_type == skvt_pkg::TYPE_CHAR) ? {24'd0, w.value[7:0]} : w.value;
      for (int i = shadow_count; i > pos; i--) shadow[i] = shadow[i-1];
      shadow[pos].key    = w.key;
      shadow[pos].etype  = w.value_type;
      shadow[pos].evalue = stored;
      shadow_count++;
      awaited_words.push_back(done_word(skvt_pkg::ST_OK, w.key, w.value_type, stored));
    end else if (w.kind == skvt_pkg::KIND_LOOKUP) begin
      while (pos < shadow_count && $signed(shadow[pos].key) < $signed(w.key)) pos++;
      if (pos >= shadow_count || shadow[pos].key != w.key)
        awaited_words.push_back(done_word(skvt_pkg::ST_NOTFOUND, w.key, '0, '0));
      else if (shadow[pos].etype != w.value_type)
        awaited_words.push_back(done_word(skvt_pkg::ST_MISMATCH, w.key,
                                          shadow[pos].etype, '0));
      else
        awaited_words.push_back(done_word(skvt_pkg::ST_OK, w.key, shadow[pos].etype,
                                          shadow[pos].evalue));
    end else if (w.kind == skvt_pkg::KIND_LIST) begin
      if (shadow_count == 0) begin
        awaited_words.push_back(done_word(skvt_pkg::ST_EMPTY, '0, '0, '0));
      end else begin
        for (int i = 0; i < shadow_count; i++) begin
          r = done_word(skvt_pkg::ST_OK, shadow[i].key, shadow[i].etype, shadow[i].evalue);
          r.last = (i == shadow_count - 1);
          awaited_words.push_back(r);
        end
      end
    end
    // kind three: no words, no change
  endfunction

  // Random operation, biased toward keys already stored so that duplicates,
  // hits and type checks dominate; neighbors and extremes probe the search.
  function automatic skvt_pkg::in_word_t random_op();
    skvt_pkg::in_word_t w;
    int pick;
    int slot;
    pick = $urandom_range(0, 99);
    w.key        = $urandom;
    w.value_type = 2'($urandom_range(0, 3));
    w.value      = $urandom;
    if (pick < 8)       w.kind = KIND_UNUSED;
    else if (pick < 33) w.kind = skvt_pkg::KIND_INSERT;
    else if (pick < 78) w.kind = skvt_pkg::KIND_LOOKUP;
    else                w.kind = skvt_pkg::KIND_LIST;
    if (shadow_count > 0 && w.kind != skvt_pkg::KIND_LIST) begin
      slot = $urandom_range(0, shadow_count - 1);
      case ($urandom_range(0, 9))
        0, 1: begin
        end
        2: w.key = shadow[slot].key + 1;
        3: w.key = shadow[slot].key - 1;
        4: w.key = $urandom_range(0, 1) ? KEY_MIN : KEY_MAX;
        default: begin
          w.key = shadow[slot].key;
          if (w.kind == skvt_pkg::KIND_LOOKUP && $urandom_range(0, 1))
            w.value_type = shadow[slot].etype;
        end
      endcase
    end
    return w;
  endfunction

  // Present one word and return at the edge that takes it. Valid is only
  // lowered for an idle cycle, so back-to-back words keep it high.
  task automatic send_word(input skvt_pkg::in_word_t w, input bit known,
                           input skvt_pkg::out_word_t result);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid    <= 1'b1;
    in_word     <= w;
    word_known  <= known;
    word_result <= result;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  // Receiver stall.
  always @(posedge clk_i) out_stall <= ($urandom_range(0, 99) < hold_pct);

  // Input acceptance feeds the shadow table; output acceptance is checked
  // against the oldest awaited word.
  always @(posedge clk_i) begin
    skvt_pkg::out_word_t want;
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        apply_table_op(in_word);
        if (in_word.kind == KIND_UNUSED) ignored_ops++;
        else applied_ops++;
        if (in_word.kind == skvt_pkg::KIND_LIST) list_ops++;
        if (word_known) begin
          void'(awaited_words.pop_back());
          awaited_words.push_back(word_result);
        end
      end
      if (out_valid && !out_stall) begin
        checked_words++;
        if (awaited_words.size() == 0) begin
          log_failure($sformatf("unexpected word: st=%0d key=%h type=%0d val=%h last=%0b",
                                out_word.status, out_word.entry_key, out_word.entry_type,
                                out_word.entry_value, out_word.last));
        end else begin
          want = awaited_words.pop_front();
          if (out_word.status !== want.status || out_word.entry_key !== want.entry_key ||
              out_word.entry_type !== want.entry_type ||
              out_word.entry_value !== want.entry_value || out_word.last !== want.last)
            log_failure({
              $sformatf("word %0d: exp st=%0d key=%h type=%0d val=%h last=%0b",
                        checked_words, want.status, want.entry_key, want.entry_type,
                        want.entry_value, want.last),
              $sformatf(", got st=%0d key=%h type=%0d val=%h last=%0b",
                        out_word.status, out_word.entry_key, out_word.entry_type,
                        out_word.entry_value, out_word.last)});
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still awaited",
               cycle_count, awaited_words.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    skvt_pkg::in_word_t w;
    int n;
    // Directed script: empty table, extremes of key, every tag, the bad tag,
    // duplicates, type checks, the ignored kind, then fill to the limit.
    add_row(op_word(skvt_pkg::KIND_LIST, '0, TYPE_INT, '0), 1,
            done_word(skvt_pkg::ST_EMPTY, '0, '0, '0));
    add_row(op_word(skvt_pkg::KIND_LOOKUP, 32'sd5, TYPE_INT, '0), 1,
            done_word(skvt_pkg::ST_NOTFOUND, 32'sd5, '0, '0));
    add_row(op_word(skvt_pkg::KIND_INSERT, KEY_MIN, TYPE_INT, 32'hFFFF_FFFF), 1,
            done_word(skvt_pkg::ST_OK, KEY_MIN, TYPE_INT, 32'hFFFF_FFFF));
    add_row(op_word(skvt_pkg::KIND_INSERT, KEY_MAX, TYPE_FLOAT, 32'h0), 1,
            done_word(skvt_pkg::ST_OK, KEY_MAX, TYPE_FLOAT, 32'h0));
    // character payload keeps only its low byte
    add_row(op_word(skvt_pkg::KIND_INSERT, 32'sd0, skvt_pkg::TYPE_CHAR, 32'hABCD_EF5A), 1,
            done_word(skvt_pkg::ST_OK, 32'sd0, skvt_pkg::TYPE_CHAR, 32'h0000_005A));
    add_row(op_word(skvt_pkg::KIND_INSERT, -32'sd1, TYPE_INT, 32'h1234_5678), 1,
            done_word(skvt_pkg::ST_OK, -32'sd1, TYPE_INT, 32'h1234_5678));
    add_row(op_word(skvt_pkg::KIND_INSERT, 32'sd7, skvt_pkg::TYPE_BAD, 32'hFFFF_FFFF), 1,
            done_word(skvt_pkg::ST_MISMATCH, 32'sd7, '0, '0));
    add_row(op_word(skvt_pkg::KIND_LOOKUP, KEY_MIN, TYPE_INT, '0), 1,
            done_word(skvt_pkg::ST_OK, KEY_MIN, TYPE_INT, 32'hFFFF_FFFF));
    add_row(op_word(skvt_pkg::KIND_LOOKUP, 32'sd0, TYPE_INT, '0), 1,
            done_word(skvt_pkg::ST_MISMATCH, 32'sd0, skvt_pkg::TYPE_CHAR, '0));
    add_row(op_word(skvt_pkg::KIND_LOOKUP, 32'sd0, skvt_pkg::TYPE_BAD, '0), 1,
            done_word(skvt_pkg::ST_MISMATCH, 32'sd0, skvt_pkg::TYPE_CHAR, '0));
    add_row(op_word(skvt_pkg::KIND_LOOKUP, 32'sd0, skvt_pkg::TYPE_CHAR, '0), 1,
            done_word(skvt_pkg::ST_OK, 32'sd0, skvt_pkg::TYPE_CHAR, 32'h0000_005A));
    add_row(op_word(KIND_UNUSED, -32'sd1, skvt_pkg::TYPE_BAD, 32'hFFFF_FFFF), 0, '0);
    // Fill: keys spread over the signed range so inserts land mid-table.
    for (int i = 1; i <= DEPTH - 4; i++)
      add_row(op_word(skvt_pkg::KIND_INSERT,
                      i * 32'h1357_9BDF + 32'h100 + $urandom_range(0, 255),
                      2'($urandom_range(0, 2)), $urandom), 0, '0);
    add_row(op_word(skvt_pkg::KIND_INSERT, 32'sd12345, TYPE_INT, 32'h1), 1,
            done_word(skvt_pkg::ST_FULL, 32'sd12345, '0, '0));
    // duplicate reported even on a full table
    add_row(op_word(skvt_pkg::KIND_INSERT, KEY_MIN, TYPE_FLOAT, 32'h1), 1,
            done_word(skvt_pkg::ST_DUP, KEY_MIN, TYPE_INT, '0));
    add_row(op_word(skvt_pkg::KIND_LIST, '0, TYPE_INT, '0), 0, '0);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) send_word(script[i].op, script[i].known_result, script[i].result);

    // Random traffic under each idling mix.
    for (int ph = 0; ph < 4; ph++) begin
      gap_pct  = gap_by_phase[ph];
      hold_pct = hold_by_phase[ph];
      n = 0;
      while (n < RANDOM_PER_PHASE) begin
        w = random_op();
        n++;
        send_word(w, 1'b0, '0);
      end
    end
    in_valid <= 1'b0;

    // let the last accepted word reach the shadow table first
    @(posedge clk_i);
    while (awaited_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d operations applied (%0d lists), %0d ignored, %0d result words checked",
             applied_ops, list_ops, ignored_ops, checked_words);
    $display("table ended with %0d of %0d entries, %0d failures",
             shadow_count, DEPTH, fail_count);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
